### design/sic_pkg.sv
`timescale 1ns / 1ps
package sic_pkg;

  // control that travels with each beat down the pipeline
  typedef struct packed {
    logic vld;
    logic skip;
  } sic_ctl_t;

endpackage

### design/sic_cell.sv
`timescale 1ns / 1ps
module sic_cell import sic_pkg::*; #(
  parameter int NW = 51,
  parameter int DW = 35,
  parameter int SW = 130
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  sic_ctl_t      ctl_in,
  input  logic [DW-1:0] div_in,
  input  logic [DW-1:0] rem_x_in,
  input  logic [NW-1:0] acc_x_in,
  input  logic [DW-1:0] rem_y_in,
  input  logic [NW-1:0] acc_y_in,
  input  logic [SW-1:0] side_in,
  output sic_ctl_t      ctl,
  output logic [DW-1:0] div,
  output logic [DW-1:0] rem_x,
  output logic [NW-1:0] acc_x,
  output logic [DW-1:0] rem_y,
  output logic [NW-1:0] acc_y,
  output logic [SW-1:0] side
);

  logic [DW:0]   tx, ty, dx, dy;
  logic          gx, gy;
  logic [DW-1:0] rem_x_next, rem_y_next;
  logic [NW-1:0] acc_x_next, acc_y_next;

  // one restoring step per lane: shift in next numerator bit, try subtract
  always_comb begin
    tx = {rem_x_in, acc_x_in[NW-1]};
    ty = {rem_y_in, acc_y_in[NW-1]};
    dx = tx - {1'b0, div_in};
    dy = ty - {1'b0, div_in};
    gx = (tx >= {1'b0, div_in});
    gy = (ty >= {1'b0, div_in});
    rem_x_next = gx ? dx[DW-1:0] : tx[DW-1:0];
    rem_y_next = gy ? dy[DW-1:0] : ty[DW-1:0];
    acc_x_next = {acc_x_in[NW-2:0], gx};
    acc_y_next = {acc_y_in[NW-2:0], gy};
  end

  // hand everything to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else if (adv) begin
      ctl.vld <= ctl_in.vld;
    end
    if (adv) begin
      ctl.skip <= ctl_in.skip;
      div      <= div_in;
      rem_x    <= rem_x_next;
      rem_y    <= rem_y_next;
      acc_x    <= acc_x_next;
      acc_y    <= acc_y_next;
      side     <= side_in;
    end
  end

endmodule

### design/segment_intersection_unit.sv
`timescale 1ns / 1ps
// an input beat passes the input register, stages 2 to 6, the divider chain and the output register
// throughput: one beat per cycle; the whole pipeline stalls together on out_ready
// the quotient comes from a chain of 3*COORD_WIDTH+3 divider cells, one bit per cell
// reset: synchronous, clears all valid flags; payload registers are not reset
module segment_intersection_unit import sic_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] first_start_x,
  input  logic signed [COORD_WIDTH-1:0] first_start_y,
  input  logic signed [COORD_WIDTH-1:0] first_end_x,
  input  logic signed [COORD_WIDTH-1:0] first_end_y,
  input  logic signed [COORD_WIDTH-1:0] second_start_x,
  input  logic signed [COORD_WIDTH-1:0] second_start_y,
  input  logic signed [COORD_WIDTH-1:0] second_end_x,
  input  logic signed [COORD_WIDTH-1:0] second_end_y,
  input  logic                          shared_endpoint,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic signed [COORD_WIDTH-1:0] cross_x,
  output logic signed [COORD_WIDTH-1:0] cross_y
);

  localparam int W  = COORD_WIDTH;
  localparam int CW = 8 * W;
  localparam int NW = 3 * W + 3;
  localparam int DW = 2 * W + 3;
  localparam int SW = CW + 2;

  logic adv;
  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  // stage 1: input register
  logic          v1, sh1;
  logic [CW-1:0] c1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      sh1 <= shared_endpoint;
      c1  <= {first_start_x, first_start_y, first_end_x, first_end_y,
              second_start_x, second_start_y, second_end_x, second_end_y};
    end
  end

  logic signed [W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  assign x1 = c1[7*W +: W];
  assign y1 = c1[6*W +: W];
  assign x2 = c1[5*W +: W];
  assign y2 = c1[4*W +: W];
  assign x3 = c1[3*W +: W];
  assign y3 = c1[2*W +: W];
  assign x4 = c1[1*W +: W];
  assign y4 = c1[0 +: W];

  // stage 2: differences and first products
  logic signed [W:0]     dx12_c, dy12_c, dx34_c, dy34_c;
  logic signed [W:0]     dx12, dy12, dx34, dy34;
  logic signed [2*W+1:0] ma, mb;
  logic signed [2*W-1:0] mc, md, me, mf;
  logic                  v2, sh2;
  logic [CW-1:0]         c2;
  always_comb begin
    dx12_c = {x1[W-1], x1} - {x2[W-1], x2};
    dy12_c = {y1[W-1], y1} - {y2[W-1], y2};
    dx34_c = {x3[W-1], x3} - {x4[W-1], x4};
    dy34_c = {y3[W-1], y3} - {y4[W-1], y4};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      sh2  <= sh1;
      c2   <= c1;
      dx12 <= dx12_c;
      dy12 <= dy12_c;
      dx34 <= dx34_c;
      dy34 <= dy34_c;
      ma   <= dx12_c * dy34_c;
      mb   <= dy12_c * dx34_c;
      mc   <= x1 * y2;
      md   <= y1 * x2;
      me   <= x3 * y4;
      mf   <= y3 * x4;
    end
  end

  // stage 3: determinant and the two cross terms
  logic signed [DW-1:0]  det3;
  logic signed [2*W:0]   pre3, post3;
  logic signed [W:0]     dx12_3, dy12_3, dx34_3, dy34_3;
  logic                  v3, sh3;
  logic [CW-1:0]         c3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      sh3    <= sh2;
      c3     <= c2;
      det3   <= {ma[2*W+1], ma} - {mb[2*W+1], mb};
      pre3   <= {mc[2*W-1], mc} - {md[2*W-1], md};
      post3  <= {me[2*W-1], me} - {mf[2*W-1], mf};
      dx12_3 <= dx12;
      dy12_3 <= dy12;
      dx34_3 <= dx34;
      dy34_3 <= dy34;
    end
  end

  // stage 4: numerator products
  logic signed [3*W+1:0] px1, px2, py1, py2;
  logic signed [DW-1:0]  det4;
  logic                  v4, sh4;
  logic [CW-1:0]         c4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      sh4  <= sh3;
      c4   <= c3;
      det4 <= det3;
      px1  <= pre3 * dx34_3;
      px2  <= dx12_3 * post3;
      py1  <= pre3 * dy34_3;
      py2  <= dy12_3 * post3;
    end
  end

  // stage 5: numerators, skip flag
  logic signed [NW-1:0] nx5, ny5;
  logic signed [DW-1:0] det5;
  logic                 v5, sk5;
  logic [CW-1:0]        c5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      sk5  <= sh4 || (det4 == '0);
      c5   <= c4;
      det5 <= det4;
      nx5  <= {px1[3*W+1], px1} - {px2[3*W+1], px2};
      ny5  <= {py1[3*W+1], py1} - {py2[3*W+1], py2};
    end
  end

  // stage 6: magnitudes and quotient signs
  sic_ctl_t      ctl6;
  logic [DW-1:0] dm6;
  logic [NW-1:0] nxm6, nym6;
  logic [SW-1:0] side6;
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl6.vld <= 1'b0;
    end else if (adv) begin
      ctl6.vld <= v5;
    end
    if (adv) begin
      ctl6.skip <= sk5;
      dm6       <= det5[DW-1] ? (~det5 + 1'b1) : det5;
      nxm6      <= nx5[NW-1] ? (~nx5 + 1'b1) : nx5;
      nym6      <= ny5[NW-1] ? (~ny5 + 1'b1) : ny5;
      side6     <= {c5, nx5[NW-1] ^ det5[DW-1], ny5[NW-1] ^ det5[DW-1]};
    end
  end

  // divider chain: one quotient bit per cell
  sic_ctl_t      ctl_c [0:NW];
  logic [DW-1:0] div_c [0:NW];
  logic [DW-1:0] rx_c  [0:NW];
  logic [NW-1:0] ax_c  [0:NW];
  logic [DW-1:0] ry_c  [0:NW];
  logic [NW-1:0] ay_c  [0:NW];
  logic [SW-1:0] sd_c  [0:NW];

  assign ctl_c[0] = ctl6;
  assign div_c[0] = dm6;
  assign rx_c[0]  = '0;
  assign ax_c[0]  = nxm6;
  assign ry_c[0]  = '0;
  assign ay_c[0]  = nym6;
  assign sd_c[0]  = side6;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    sic_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .ctl_in   (ctl_c[i]),
      .div_in   (div_c[i]),
      .rem_x_in (rx_c[i]),
      .acc_x_in (ax_c[i]),
      .rem_y_in (ry_c[i]),
      .acc_y_in (ay_c[i]),
      .side_in  (sd_c[i]),
      .ctl      (ctl_c[i+1]),
      .div      (div_c[i+1]),
      .rem_x    (rx_c[i+1]),
      .acc_x    (ax_c[i+1]),
      .rem_y    (ry_c[i+1]),
      .acc_y    (ay_c[i+1]),
      .side     (sd_c[i+1])
    );
  end

  // signed quotients and bounding box test
  sic_ctl_t           ctl_e;
  logic [CW-1:0]      ce;
  logic               sxe, sye;
  logic signed [NW:0] qx, qy;
  logic signed [NW:0] ex1, ey1, ex2, ey2, ex3, ey3, ex4, ey4;
  logic               in_box, hit_next;

  assign ctl_e = ctl_c[NW];
  assign ce    = sd_c[NW][SW-1:2];
  assign sxe   = sd_c[NW][1];
  assign sye   = sd_c[NW][0];

  always_comb begin
    qx  = sxe ? -$signed({1'b0, ax_c[NW]}) : $signed({1'b0, ax_c[NW]});
    qy  = sye ? -$signed({1'b0, ay_c[NW]}) : $signed({1'b0, ay_c[NW]});
    ex1 = {{(NW+1-W){ce[8*W-1]}}, ce[7*W +: W]};
    ey1 = {{(NW+1-W){ce[7*W-1]}}, ce[6*W +: W]};
    ex2 = {{(NW+1-W){ce[6*W-1]}}, ce[5*W +: W]};
    ey2 = {{(NW+1-W){ce[5*W-1]}}, ce[4*W +: W]};
    ex3 = {{(NW+1-W){ce[4*W-1]}}, ce[3*W +: W]};
    ey3 = {{(NW+1-W){ce[3*W-1]}}, ce[2*W +: W]};
    ex4 = {{(NW+1-W){ce[2*W-1]}}, ce[1*W +: W]};
    ey4 = {{(NW+1-W){ce[W-1]}},   ce[0 +: W]};
    in_box = ((qx >= ex1) || (qx >= ex2)) && ((qx <= ex1) || (qx <= ex2)) &&
             ((qx >= ex3) || (qx >= ex4)) && ((qx <= ex3) || (qx <= ex4)) &&
             ((qy >= ey1) || (qy >= ey2)) && ((qy <= ey1) || (qy <= ey2)) &&
             ((qy >= ey3) || (qy >= ey4)) && ((qy <= ey3) || (qy <= ey4));
    hit_next = !ctl_e.skip && in_box;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl_e.vld;
    end
    if (adv) begin
      hit     <= hit_next;
      cross_x <= hit_next ? qx[W-1:0] : '0;
      cross_y <= hit_next ? qy[W-1:0] : '0;
    end
  end

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> cross_x == '0 && cross_y == '0)
    else $error("miss with nonzero point");

  a_skip_no_hit: assert property (@(posedge clk) disable iff (rst)
    adv && ctl_e.vld && ctl_e.skip |=> out_valid && !hit)
    else $error("skipped beat reported a hit");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !ctl_c[NW].vld)
    else $error("valid set right after reset");
`endif

endmodule

### verif/segment_intersection_checker.sv
`timescale 1ns / 1ps
module segment_intersection_checker #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] first_start_x,
  input  logic signed [COORD_WIDTH-1:0] first_start_y,
  input  logic signed [COORD_WIDTH-1:0] first_end_x,
  input  logic signed [COORD_WIDTH-1:0] first_end_y,
  input  logic signed [COORD_WIDTH-1:0] second_start_x,
  input  logic signed [COORD_WIDTH-1:0] second_start_y,
  input  logic signed [COORD_WIDTH-1:0] second_end_x,
  input  logic signed [COORD_WIDTH-1:0] second_end_y,
  input  logic                          shared_endpoint,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          hit,
  input  logic signed [COORD_WIDTH-1:0] cross_x,
  input  logic signed [COORD_WIDTH-1:0] cross_y,
  output int                            fail_count,
  output int                            pending_count
);

  typedef struct {
    logic                   hit;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
  } crossing_t;

  crossing_t crossing_q[$];

  // inclusive range test against a box edge pair
  function automatic bit in_span(longint v, longint a, longint b);
    longint lo;
    longint hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return v >= lo && v <= hi;
  endfunction

  // signed quotient truncated toward zero, exact in 128 bits
  function automatic logic signed [127:0] trunc_div(logic signed [127:0] n,
                                                   logic signed [127:0] d);
    logic [127:0] un;
    logic [127:0] ud;
    logic [127:0] q;
    un = n[127] ? -n : n;
    ud = d[127] ? -d : d;
    q = un / ud;
    return (n[127] != d[127]) ? -$signed(q) : $signed(q);
  endfunction

  function automatic crossing_t predict_crossing(longint x1, longint y1, longint x2,
                                                 longint y2, longint x3, longint y3,
                                                 longint x4, longint y4, logic shared);
    crossing_t r;
    logic signed [127:0] dx12, dy12, dx34, dy34, det, pre, post, qx, qy;
    r = '{hit: 1'b0, x: '0, y: '0};
    dx12 = x1 - x2;
    dy12 = y1 - y2;
    dx34 = x3 - x4;
    dy34 = y3 - y4;
    det = dx12 * dy34 - dy12 * dx34;
    if (shared || det == 0) return r;
    pre = longint'(x1) * longint'(y2) - longint'(y1) * longint'(x2);
    post = longint'(x3) * longint'(y4) - longint'(y3) * longint'(x4);
    qx = trunc_div(pre * dx34 - dx12 * post, det);
    qy = trunc_div(pre * dy34 - dy12 * post, det);
    if (qx > 128'sd40000 || qx < -128'sd40000) return r;
    if (qy > 128'sd40000 || qy < -128'sd40000) return r;
    if (!in_span(longint'(qx), x1, x2) || !in_span(longint'(qx), x3, x4)) return r;
    if (!in_span(longint'(qy), y1, y2) || !in_span(longint'(qy), y3, y4)) return r;
    r.hit = 1'b1;
    r.x = qx[COORD_WIDTH-1:0];
    r.y = qy[COORD_WIDTH-1:0];
    return r;
  endfunction

  // predict on input beats, compare on output beats
  always @(posedge clk) begin
    crossing_t want;
    if (rst) begin
      crossing_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        crossing_q.push_back(predict_crossing(first_start_x, first_start_y, first_end_x,
          first_end_y, second_start_x, second_start_y, second_end_x, second_end_y,
          shared_endpoint));
      if (out_valid && out_ready) begin
        if (crossing_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat hit=%0b", hit);
          fail_count <= fail_count + 1;
        end else begin
          want = crossing_q.pop_front();
          if (hit !== want.hit || cross_x !== want.x || cross_y !== want.y) begin
            if (fail_count < 10)
              $display("mismatch: want hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                want.hit, $signed(want.x), $signed(want.y), hit, cross_x, cross_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= crossing_q.size();
  end

endmodule

### verif/segment_intersection_unit_tb.sv
`timescale 1ns / 1ps
module segment_intersection_unit_tb;
  import sic_pkg::*;

  localparam int W = 16;
  localparam int RANDOM_BEATS = 2000;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [W-1:0] coord [8];
  logic shared_endpoint = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic signed [W-1:0] cross_x;
  logic signed [W-1:0] cross_y;
  int fail_count;
  int pending_count;
  int idle_cycles = 0;
  bit quiet_tail = 1'b0;

  initial for (int i = 0; i < 8; i++) coord[i] = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_intersection_unit #(.COORD_WIDTH(W)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .first_start_x(coord[0]), .first_start_y(coord[1]),
    .first_end_x(coord[2]), .first_end_y(coord[3]),
    .second_start_x(coord[4]), .second_start_y(coord[5]),
    .second_end_x(coord[6]), .second_end_y(coord[7]),
    .shared_endpoint(shared_endpoint), .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .cross_x(cross_x), .cross_y(cross_y)
  );

  segment_intersection_checker #(.COORD_WIDTH(W)) i_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .first_start_x(coord[0]), .first_start_y(coord[1]),
    .first_end_x(coord[2]), .first_end_y(coord[3]),
    .second_start_x(coord[4]), .second_start_y(coord[5]),
    .second_end_x(coord[6]), .second_end_y(coord[7]),
    .shared_endpoint(shared_endpoint), .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .cross_x(cross_x), .cross_y(cross_y),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // send one beat, holding it until accepted
  task automatic send_pair(input logic signed [W-1:0] c [8], input logic sh);
    in_valid <= 1'b1;
    for (int i = 0; i < 8; i++) coord[i] <= c[i];
    shared_endpoint <= sh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // a crossing candidate: two segments spanning opposite quadrants around a random point
  task automatic make_crossing(output logic signed [W-1:0] c [8], input int span);
    int px, py;
    px = $urandom_range(0, 2 * (32767 - span)) - (32767 - span);
    py = $urandom_range(0, 2 * (32767 - span)) - (32767 - span);
    c[0] = W'(px - $urandom_range(0, span)); c[1] = W'(py - $urandom_range(0, span));
    c[2] = W'(px + $urandom_range(0, span)); c[3] = W'(py + $urandom_range(0, span));
    c[4] = W'(px - $urandom_range(0, span)); c[5] = W'(py + $urandom_range(0, span));
    c[6] = W'(px + $urandom_range(0, span)); c[7] = W'(py - $urandom_range(0, span));
  endtask

  initial begin
    logic signed [W-1:0] c [8];
    int kind;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain cross, shared endpoint, parallel, collinear, degenerate, outside box, full-range and edge cases
    c = '{-16, -16, 16, 16, -16, 16, 16, -16}; send_pair(c, 1'b0);
    send_pair(c, 1'b1);
    c = '{0, 0, 32, 0, 0, 16, 32, 16}; send_pair(c, 1'b0);
    c = '{0, 0, 32, 32, 48, 48, 64, 64}; send_pair(c, 1'b0);
    c = '{5, 5, 5, 5, 5, 5, 5, 5}; send_pair(c, 1'b0);
    c = '{0, 0, 16, 16, 100, 0, 116, -16}; send_pair(c, 1'b0);
    c = '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768};
    send_pair(c, 1'b0);
    c = '{32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768};
    send_pair(c, 1'b0);
    c = '{-32768, 0, 32767, 0, 0, -32768, 0, 32767}; send_pair(c, 1'b0);
    c = '{0, 0, 48, 0, 48, -16, 48, 16}; send_pair(c, 1'b0);
    c = '{1, 0, 2, 7, 0, 3, 3, 2}; send_pair(c, 1'b0);
    c = '{-1, -1, -1, -1, 0, 0, 0, 0}; send_pair(c, 1'b0);

    // random: mostly crossing pairs, some noise and near misses
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n > RANDOM_BEATS - 200) quiet_tail = 1'b1;
      sender_gap();
      kind = $urandom_range(0, 9);
      if (kind < 5) make_crossing(c, (kind < 3) ? 300 : 16000);
      else if (kind < 8) for (int i = 0; i < 8; i++) c[i] = W'($urandom);
      else begin
        make_crossing(c, 64);
        c[4] = W'(c[0] + 1); c[5] = c[1]; c[6] = W'(c[2] + 1); c[7] = c[3];
      end
      send_pair(c, $urandom_range(0, 7) == 0);
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (3 * W + 20) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
